[rtl/ssst_pkg.sv]
// Shared field widths, operation codes and status codes of the sorted successor table.
package ssst_pkg;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 14;
    localparam int SLOT_W   = 6;
    localparam int NEXT_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 14'd10000;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

[rtl/ssst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/stable_sorted_successor_table_unit.sv]
// Stable sorted successor table: slot store with links in stable ascending value order.
// Clear, rejected insert/read, unused op go straight to the result; other reads wait on the RAM.
// An insert scans every filled slot for its predecessor, one value RAM read and compare per
//   cycle, then reads the predecessor's link (not at a new head), writes the slot and splices.
// Throughput: one item at a time; the next item is taken once the result is delivered.
// Reset: synchronous, active low; empties the table (fill count 0, head none) at once.
module stable_sorted_successor_table_unit
    import ssst_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [SLOT_W-1:0]   i_slot,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [VALUE_W-1:0]  o_value_out,
    output logic [NEXT_W-1:0]   o_next_slot,
    output logic [STATUS_W-1:0] o_status
);

    // AW addresses a slot; CW holds a fill count or a link, both of which reach DEPTH.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0]     NONE_LINK = CW'(DEPTH);
    localparam logic [NEXT_W-1:0] NONE_OUT  = NEXT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_LINK_WAIT,
        S_WRITE,
        S_SPLICE,
        S_READ_WAIT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_head;
    logic [VALUE_W-1:0]  r_val;
    logic [CW-1:0]       r_idx;       // next slot to read during the scan
    logic                r_pend;      // a scan read is in flight
    logic [AW-1:0]       r_cmp_idx;   // slot of the data now on the RAM output
    logic                r_found;     // some entry is not above the new value
    logic [AW-1:0]       r_best;      // predecessor slot so far
    logic [VALUE_W-1:0]  r_best_val;
    logic [CW-1:0]       r_cur;       // successor of the new slot
    logic [SLOT_W-1:0]   r_slot_out;
    logic [VALUE_W-1:0]  r_value_out;
    logic [NEXT_W-1:0]   r_next_out;
    logic [STATUS_W-1:0] r_status;

    logic                val_we;
    logic                link_we;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       link_waddr;
    logic [CW-1:0]       link_wdata;
    logic [VALUE_W-1:0]  val_rdata;
    logic [CW-1:0]       link_rdata;
    logic                take;
    logic                cmp_hit;
    logic                read_ok;

    assign take    = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    // Scan compare: the entry is not above the new value and is at least the best so far.
    // Slots come in ascending order, so ties go to the later slot, which keeps order stable.
    assign cmp_hit = (val_rdata <= r_val) && (!r_found || (val_rdata >= r_best_val));

    assign read_ok = (32'(i_slot) < 32'(DEPTH)) && (32'(i_slot) < 32'(r_fill));

    // RAM port steering per sequencer step
    always_comb begin
        val_we     = 1'b0;
        link_we    = 1'b0;
        raddr      = r_best;
        link_waddr = r_fill[AW-1:0];
        link_wdata = r_cur;
        unique case (r_state)
            S_IDLE: begin
                raddr = AW'(i_slot);
            end
            S_SCAN: begin
                raddr = r_idx[AW-1:0];
            end
            S_WRITE: begin
                val_we  = 1'b1;
                link_we = 1'b1;
            end
            S_SPLICE: begin
                link_we    = r_found;
                link_waddr = r_best;
                link_wdata = r_fill;
            end
            default: begin
                raddr = r_best;
            end
        endcase
    end

    ssst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    ssst_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (raddr),
        .o_rdata (link_rdata)
    );

    // Sequencer: state, table bookkeeping and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_head  <= NONE_LINK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        // default result: nothing stored, tail successor
                        r_slot_out  <= '0;
                        r_value_out <= '0;
                        r_next_out  <= NONE_OUT;
                        r_status    <= ST_OK;
                        r_state     <= S_DONE;
                        unique case (i_op)
                            OP_CLEAR: begin
                                r_fill <= '0;
                                r_head <= NONE_LINK;
                            end
                            OP_INSERT: begin
                                if (i_value > VALUE_LIMIT) begin
                                    r_status <= ST_RANGE;
                                end else if (r_fill >= NONE_LINK) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_val   <= i_value;
                                    r_idx   <= '0;
                                    r_pend  <= 1'b0;
                                    r_found <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_READ: begin
                                r_slot_out <= i_slot;
                                if (read_ok) begin
                                    // RAM read was issued this cycle from the slot field
                                    r_state <= S_READ_WAIT;
                                end else begin
                                    r_status <= ST_EMPTY;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // evaluate the entry read last cycle
                    if (r_pend && cmp_hit) begin
                        r_found    <= 1'b1;
                        r_best     <= r_cmp_idx;
                        r_best_val <= val_rdata;
                    end
                    // issue the next read, or drain and move on
                    if (r_idx < r_fill) begin
                        r_pend    <= 1'b1;
                        r_cmp_idx <= r_idx[AW-1:0];
                        r_idx     <= r_idx + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_LINK;
                        end
                    end
                end
                S_LINK: begin
                    // the predecessor's link is read here; with none, the new slot heads the list
                    if (r_found) begin
                        r_state <= S_LINK_WAIT;
                    end else begin
                        r_cur   <= r_head;
                        r_state <= S_WRITE;
                    end
                end
                S_LINK_WAIT: begin
                    r_cur   <= link_rdata;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    // value and successor of the new slot are written this cycle
                    r_state <= S_SPLICE;
                end
                S_SPLICE: begin
                    if (!r_found) begin
                        r_head <= r_fill;
                    end
                    r_fill      <= r_fill + 1'b1;
                    r_slot_out  <= SLOT_W'(r_fill);
                    r_value_out <= r_val;
                    r_next_out  <= NEXT_W'(r_cur);
                    r_status    <= ST_OK;
                    r_state     <= S_DONE;
                end
                S_READ_WAIT: begin
                    r_value_out <= val_rdata;
                    r_next_out  <= NEXT_W'(link_rdata);
                    r_status    <= ST_OK;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    // hold the result until the receiver takes it
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_slot_out  = r_slot_out;
    assign o_value_out = r_value_out;
    assign o_next_slot = r_next_out;
    assign o_status    = r_status;

endmodule

[tb/table_check_pkg.sv]
// Result record, test codes and the scoreboard class for the sorted successor table bench.
`timescale 1ns / 100ps
package table_check_pkg;
    import ssst_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam logic [NEXT_W-1:0] NO_SUCCESSOR = 7'd64;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  value;
        logic [NEXT_W-1:0]   successor;
        logic [STATUS_W-1:0] status;
    } t_table_result;

    class t_successor_table_scoreboard;
        int unsigned   stored_value[TABLE_DEPTH];
        int unsigned   stored_link[TABLE_DEPTH];
        int unsigned   fill_count;
        int unsigned   head_slot;
        t_table_result expected_q[$];
        int unsigned   mismatches;

        function new();
            fill_count = 0;
            head_slot  = TABLE_DEPTH;
            mismatches = 0;
        endfunction

        // Update the table copy for one accepted item and queue the result it must give.
        function void note_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                logic [SLOT_W-1:0] slot);
            t_table_result res;
            int unsigned   prev;
            int unsigned   cur;
            int unsigned   steps;
            int unsigned   fresh;
            res.slot      = '0;
            res.value     = '0;
            res.successor = NO_SUCCESSOR;
            res.status    = ST_OK;
            case (op)
                OP_CLEAR: begin
                    fill_count = 0;
                    head_slot  = TABLE_DEPTH;
                end
                OP_INSERT: begin
                    if (value > VALUE_LIMIT) begin
                        res.status = ST_RANGE;
                    end else if (fill_count >= TABLE_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        // walk to the first entry whose value is above the new one
                        prev  = TABLE_DEPTH;
                        cur   = head_slot;
                        steps = 0;
                        fresh = fill_count;
                        while (cur < TABLE_DEPTH && steps < fill_count &&
                               stored_value[cur] <= value) begin
                            prev = cur;
                            cur  = stored_link[cur];
                            steps++;
                        end
                        stored_value[fresh] = value;
                        stored_link[fresh]  = cur;
                        if (prev < TABLE_DEPTH) begin
                            stored_link[prev] = fresh;
                        end else begin
                            head_slot = fresh;
                        end
                        fill_count    = fresh + 1;
                        res.slot      = SLOT_W'(fresh);
                        res.value     = value;
                        res.successor = NEXT_W'(cur);
                    end
                end
                OP_READ: begin
                    res.slot = slot;
                    if (slot >= fill_count) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.value     = VALUE_W'(stored_value[slot]);
                        res.successor = NEXT_W'(stored_link[slot]);
                    end
                end
                default: begin
                end
            endcase
            expected_q.push_back(res);
        endfunction

        // Compare one delivered result with the oldest queued one.
        function void check_result(t_table_result got);
            t_table_result exp;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result slot=%0d value=%0d next=%0d status=%0d",
                             $realtime, got.slot, got.value, got.successor, got.status);
                return;
            end
            exp = expected_q.pop_front();
            if (got != exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             $realtime, exp.slot, exp.value, exp.successor, exp.status,
                             got.slot, got.value, got.successor, got.status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass
endpackage

[tb/stable_sorted_successor_table_unit_test.sv]
// Top-level bench of the sorted successor table: stimulus, handshakes, checking and watchdog.
`timescale 1ns / 100ps
module stable_sorted_successor_table_unit_test
    import ssst_pkg::*, table_check_pkg::*;
;

    localparam int ITEM_TARGET     = 1350;
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off, fills the block
    localparam int HOLD_ITEMS      = 4;     // items offered while the receiver holds off
    localparam int IDLE_LIMIT      = 4000;  // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES    = 80;    // settle time before the verdict

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [OP_W-1:0]     i_op = OP_CLEAR;
    logic [VALUE_W-1:0]  i_value = '0;
    logic [SLOT_W-1:0]   i_slot = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [SLOT_W-1:0]   o_slot_out;
    logic [VALUE_W-1:0]  o_value_out;
    logic [NEXT_W-1:0]   o_next_slot;
    logic [STATUS_W-1:0] o_status;

    t_successor_table_scoreboard table_sb;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    bit          hold_request = 1'b0;

    stable_sorted_successor_table_unit #(
        .DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_slot      (i_slot),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_slot_out  (o_slot_out),
        .o_value_out (o_value_out),
        .o_next_slot (o_next_slot),
        .o_status    (o_status)
    );

    always #6 i_clk = ~i_clk;

    // Offer one item and hold it until the block takes it. The idle gap, if the
    // current burst is over, comes first so valid is never lowered and raised in
    // one time step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                             input logic [SLOT_W-1:0] slot);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= value;
        i_slot  <= slot;
        do @(posedge i_clk); while (o_stall);
        table_sb.note_item(op, value, slot);
        items_sent++;
    endtask

    // Drop valid and hold the sender until every queued result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (table_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mix plain values, tight ranges that force ties, limits and rejected values.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_W'($urandom_range(0, 10000));
            4, 5:       return VALUE_W'($urandom_range(0, 7));
            6:          return VALUE_W'($urandom_range(9990, 10001));
            7:          return VALUE_W'($urandom_range(10001, 16383));
            default:    return $urandom_range(0, 1) ? VALUE_W'(0) : VALUE_W'(10000);
        endcase
    endfunction

    // Read mostly filled slots or the one just past them, sometimes anywhere in the slot range.
    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 2) != 0 && table_sb.fill_count > 0)
            return SLOT_W'($urandom_range(0, table_sb.fill_count));
        return SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    endfunction

    // Check every delivered result against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_table_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.slot      = o_slot_out;
            got.value     = o_value_out;
            got.successor = o_next_slot;
            got.status    = o_status;
            table_sb.check_result(got);
        end
    end

    // Receiver back-pressure: change to a random stall mode when the current one ends,
    // and once hold off for a long stretch so the block backs up into its input.
    initial begin : stall_pattern
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          hold_done;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 9) < 3);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
                    default:     i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // Give up when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned count;
        bit          keep_table;
        table_sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty reads, head/tail/tie inserts, rejected values,
        // the unused op, and a clear.
        send_item(OP_READ, 14'd0, 6'd0);
        send_item(OP_INSERT, 14'd500, 6'd63);
        send_item(OP_INSERT, 14'd0, 6'd0);
        send_item(OP_INSERT, 14'd10000, 6'd0);
        send_item(OP_INSERT, 14'd500, 6'd0);
        send_item(OP_INSERT, 14'd10001, 6'd0);
        send_item(OP_INSERT, 14'd16383, 6'd63);
        send_item(OP_READ, 14'd0, 6'd0);
        send_item(OP_READ, 14'd0, 6'd1);
        send_item(OP_READ, 14'd0, 6'd2);
        send_item(OP_READ, 14'd16383, 6'd3);
        send_item(OP_READ, 14'd0, 6'd4);
        send_item(OP_READ, 14'd0, 6'd63);
        send_item(OP_UNUSED, 14'd16383, 6'd63);
        send_item(OP_CLEAR, 14'd16383, 6'd63);
        send_item(OP_READ, 14'd0, 6'd0);
        send_item(OP_INSERT, 14'd7, 6'd0);
        send_item(OP_READ, 14'd0, 6'd0);
        wait_drained();

        // Fill the table past its size: full inserts, range check ahead of the
        // full check, and reads of the last slot.
        send_item(OP_CLEAR, 14'd0, 6'd0);
        repeat (TABLE_DEPTH + 2)
            send_item(OP_INSERT, VALUE_W'($urandom_range(0, 10000)), SLOT_W'($urandom));
        send_item(OP_INSERT, 14'd16383, 6'd0);
        send_item(OP_READ, 14'd0, 6'd63);
        send_item(OP_READ, 14'd0, 6'd0);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering items.
        hold_request = 1'b1;
        repeat (HOLD_ITEMS)
            send_item(OP_READ, VALUE_W'($urandom), pick_slot());

        // Random part: mostly clear-and-build sequences, with reads and the odd
        // broken step, plus bursts of raw noise.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(3, 12))
                    send_item(OP_W'($urandom_range(0, 3)), VALUE_W'($urandom),
                              SLOT_W'($urandom));
            end else begin
                keep_table = ($urandom_range(0, 3) == 0);
                if (!keep_table)
                    send_item(OP_CLEAR, VALUE_W'($urandom), SLOT_W'($urandom));
                count = $urandom_range(0, 4) == 0 ? $urandom_range(50, 72)
                                                  : $urandom_range(1, 24);
                repeat (count) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                            send_item(OP_INSERT, pick_value(), SLOT_W'($urandom));
                        13, 14, 15, 16, 17:
                            send_item(OP_READ, VALUE_W'($urandom), pick_slot());
                        18:
                            send_item(OP_UNUSED, VALUE_W'($urandom), SLOT_W'($urandom));
                        default:
                            send_item(OP_CLEAR, VALUE_W'($urandom), SLOT_W'($urandom));
                    endcase
                end
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        // Drain, then let the block settle before the verdict.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_sb.mismatches == 0 && table_sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[files.f]
rtl/ssst_pkg.sv
rtl/ssst_ram.sv
rtl/stable_sorted_successor_table_unit.sv
tb/table_check_pkg.sv
tb/stable_sorted_successor_table_unit_test.sv
